### sv/fpns_pkg.sv
// Package for the fixed-point neuron with rational sigmoid.
// Holds field widths, fixed-point constants, the controller state type and
// the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package fpns_pkg;

	localparam int W_WEIGHT  = 14;
	localparam int W_ACT     = 16;
	localparam int W_BIAS    = 14;
	localparam int W_OUT     = 10;
	localparam int FRAC_BITS = 10;
	localparam int Q_ONE     = 1 << FRAC_BITS;
	localparam int PROD_W    = W_WEIGHT + W_ACT;
	localparam int TERM_W    = PROD_W - FRAC_BITS;
	// The quotient of the sigmoid division is always below one in Q10.
	localparam int Q_BITS    = FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(Q_BITS);

	typedef enum logic [2:0] {
		ST_RUN,
		ST_BIAS,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_x;
		logic load_div;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic last_s1;
	} dp_stat_t;

endpackage

`default_nettype wire

### sv/fpns_chan_if.sv
// Valid/ready channel interfaces for the neuron block: term input and result output.
// Depends on fpns_pkg for the field widths.
`default_nettype none

interface fpns_in_if;
	import fpns_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [W_WEIGHT-1:0]  weight;
	logic signed [W_ACT-1:0]     activation;
	logic signed [W_BIAS-1:0]    bias;
	logic                        last;

	modport source (output valid, output weight, output activation, output bias,
		output last, input ready);
	modport sink (input valid, input weight, input activation, input bias,
		input last, output ready);
endinterface

interface fpns_out_if;
	import fpns_pkg::*;

	logic               valid;
	logic               ready;
	logic [W_OUT-1:0]   activation_out;

	modport source (output valid, output activation_out, input ready);
	modport sink (input valid, input activation_out, output ready);
endinterface

`default_nettype wire

### sv/fixed_point_neuron_sigmoid.sv
// Top level of the fixed-point neuron with rational sigmoid.
// Depends on fpns_pkg, fpns_chan_if, fpns_ctrl and fpns_dp.
//
//   port    dir  interface    content
//   feed    in   fpns_in_if   weight, activation, bias, last (one term per item)
//   result  out  fpns_out_if  activation_out (one per neuron, on the last term)
//
// Terms that are not last are taken one per cycle; the multiplier is registered
// and the accumulator adds its output in the next cycle. After a last term the
// block takes no item through the accumulate, bias add, divider load, ten steps of
// the restoring divider (one quotient bit per cycle) and the result register load.
// The result register lets terms of the next neuron flow while a result waits;
// a waiting result stalls only the next sigmoid. Reset clears the accumulator.
`default_nettype none

module fixed_point_neuron_sigmoid #(
	parameter int ACC_WIDTH = 27
) (
	input  logic       clk,
	input  logic       arst_n,
	fpns_in_if.sink    feed,
	fpns_out_if.source result
);
	import fpns_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_fire;

	assign in_fire = feed.valid & feed.ready;

	fpns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.out_ready (result.ready),
		.in_ready  (feed.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	fpns_dp #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_fire        (in_fire),
		.weight         (feed.weight),
		.activation     (feed.activation),
		.bias           (feed.bias),
		.last           (feed.last),
		.cmd            (cmd),
		.stat           (stat),
		.activation_out (result.activation_out)
	);

	// A last term must reach the accumulator before anything else is taken.
	a_last_blocks_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && feed.last) |=> !feed.ready)
		else $error("item taken right after a last term");

	// The result register never loads over a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!result.valid || result.ready))
		else $error("result register loaded while occupied");

	// Datapath commands are issued one at a time.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_x, cmd.load_div, cmd.div_step, cmd.load_out}))
		else $error("more than one datapath command");

	// No new term is taken while the sigmoid is being computed.
	a_no_input_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.load_x || cmd.load_div) |-> !feed.ready)
		else $error("input ready during sigmoid");

endmodule

`default_nettype wire

### sv/fpns_dp.sv
// Datapath of the neuron: product register, wrapping accumulator, bias add,
// restoring divider for the sigmoid and the result register. Depends on fpns_pkg.
`default_nettype none

module fpns_dp #(
	parameter int ACC_WIDTH = 27
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_fire,
	input  logic signed [fpns_pkg::W_WEIGHT-1:0] weight,
	input  logic signed [fpns_pkg::W_ACT-1:0]    activation,
	input  logic signed [fpns_pkg::W_BIAS-1:0]   bias,
	input  logic                                 last,
	input  fpns_pkg::dp_cmd_t                    cmd,
	output fpns_pkg::dp_stat_t                   stat,
	output logic [fpns_pkg::W_OUT-1:0]           activation_out
);
	import fpns_pkg::*;

	// Bias sum and its magnitude fit one bit above the accumulator.
	localparam int DW = ACC_WIDTH + 1;

	logic                       valid_s1;
	logic                       last_s1;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [W_BIAS-1:0]   bias_s1;

	logic [ACC_WIDTH-1:0]        acc_q;
	logic signed [ACC_WIDTH-1:0] sum_q;
	logic signed [W_BIAS-1:0]    bias_q;
	logic signed [DW-1:0]        x_q;
	logic                        neg_q;
	logic [DW-1:0]               rem_q;
	logic [DW-1:0]               den_q;
	logic [Q_BITS-1:0]           quo_q;
	logic [W_OUT-1:0]            act_q;

	logic signed [TERM_W-1:0]    term;
	logic                        round_up;
	logic [ACC_WIDTH-1:0]        acc_next;
	logic                        x_neg;
	logic [DW-1:0]               x_inv;
	logic [DW:0]                 rem_shift;
	logic [DW:0]                 rem_diff;
	logic                        quo_bit;
	logic [Q_BITS:0]             quo_signed;
	logic [Q_BITS:0]             sig_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
			last_s1  <= in_fire & last;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			prod_s1 <= weight * activation;
			bias_s1 <= bias;
		end
	end

	// Division by 1024 toward zero: arithmetic shift, plus one for a negative
	// product with a nonzero fraction, folded in as the adder's carry.
	always_comb begin
		term     = prod_s1[PROD_W-1:FRAC_BITS];
		round_up = prod_s1[PROD_W-1] & (|prod_s1[FRAC_BITS-1:0]);
		acc_next = acc_q + ACC_WIDTH'(term) + ACC_WIDTH'(round_up);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_next;
			end
		end
	end

	always_comb begin
		x_neg      = x_q[DW-1];
		x_inv      = x_neg ? ~x_q : x_q;
		rem_shift  = {rem_q, 1'b0};
		rem_diff   = rem_shift - {1'b0, den_q};
		quo_bit    = !rem_diff[DW];
		quo_signed = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
		sig_sum    = quo_signed + (Q_BITS + 1)'(Q_ONE);
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1) begin
			sum_q  <= acc_next;
			bias_q <= bias_s1;
		end
		if (cmd.load_x) begin
			x_q <= DW'(sum_q) + DW'(bias_q);
		end
		if (cmd.load_div) begin
			// Magnitude and divisor |x| + 1024 from one's complement plus carry.
			neg_q <= x_neg;
			rem_q <= x_inv + DW'(x_neg);
			den_q <= x_inv + (x_neg ? DW'(Q_ONE + 1) : DW'(Q_ONE));
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= quo_bit ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
			quo_q <= {quo_q[Q_BITS-2:0], quo_bit};
		end
		if (cmd.load_out) begin
			act_q <= sig_sum[Q_BITS:1];
		end
	end

	assign stat.last_s1    = valid_s1 & last_s1;
	assign activation_out = act_q;

endmodule

`default_nettype wire

### sv/fpns_ctrl.sv
// Controller of the neuron: state machine that sequences bias add, divider
// load and steps, and the result hand-off; owns both handshakes. Depends on fpns_pkg.
`default_nettype none

module fpns_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  fpns_pkg::dp_stat_t stat,
	input  logic               out_ready,
	output logic               in_ready,
	output logic               out_valid,
	output fpns_pkg::dp_cmd_t  cmd
);
	import fpns_pkg::*;

	localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(Q_BITS - 1);

	state_t               state_q;
	state_t               state_next;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_RUN: begin
				// The last term is still in the product stage: hold new items off.
				in_ready = !stat.last_s1;
				if (stat.last_s1) begin
					state_next = ST_BIAS;
				end
			end
			ST_BIAS: begin
				cmd.load_x = 1'b1;
				state_next = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_div = 1'b1;
				state_next   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_next   = ST_RUN;
				end
			end
			default: begin
				state_next = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_div) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
